FILE: hdl/ray_aabb_slab_intersection_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the ray/box slab test block
// Shared helpers so that every check is written the same way.
// ----------------------------------------------------------------------------
`ifndef RAY_AABB_SLAB_INTERSECTION_DEFINES_SVH
`define RAY_AABB_SLAB_INTERSECTION_DEFINES_SVH

// Check a property on every rising edge of clk outside reset.
`define RAB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define RAB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

FILE: hdl/rab_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_pkg
// Types, constants and helpers shared by the ray/box slab test modules.
// ----------------------------------------------------------------------------
package rab_pkg;

  localparam int AXES = 3;

  localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

  // register word indexes
  localparam logic REG_EPS = 1'b0;

  // entry face codes
  localparam logic [2:0] FACE_NONE  = 3'd0;
  localparam logic [2:0] FACE_NEG_X = 3'd1;
  localparam logic [2:0] FACE_POS_X = 3'd2;
  localparam logic [2:0] FACE_NEG_Y = 3'd3;
  localparam logic [2:0] FACE_POS_Y = 3'd4;
  localparam logic [2:0] FACE_NEG_Z = 3'd5;
  localparam logic [2:0] FACE_POS_Z = 3'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic               active;   // axis constrains the ray
    logic               miss;     // parallel and origin outside the slab
    logic               swapped;  // upper corner entered first
    logic signed [31:0] t_in;
    logic signed [31:0] t_out;
  } lane_res_t;

  typedef struct packed {
    logic        hit;
    logic [30:0] tnear;
    logic [2:0]  face;
  } merge_res_t;

  function automatic logic signed [31:0] sat64_to32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32_MAX)) begin
      r = S32_MAX;
    end else if (v < 64'(S32_MIN)) begin
      r = S32_MIN;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic logic [2:0] face_of(input logic [1:0] axis, input logic swapped);
    logic [2:0] f;
    unique case (axis)
      AXIS_X:  f = swapped ? FACE_POS_X : FACE_NEG_X;
      AXIS_Y:  f = swapped ? FACE_POS_Y : FACE_NEG_Y;
      AXIS_Z:  f = swapped ? FACE_POS_Z : FACE_NEG_Z;
      default: f = FACE_NONE;
    endcase
    return f;
  endfunction

endpackage

FILE: hdl/rab_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_div
// Pipelined restoring divider, one quotient bit per stage, saturated result.
// ----------------------------------------------------------------------------
module rab_div #(
  parameter int NW = 48
) (
  input  logic                clk,
  input  logic                en,
  input  logic [NW-1:0]       num,
  input  logic [31:0]         den,
  input  logic                neg,
  output logic signed [31:0]  quot
);
  import rab_pkg::*;

  logic [NW-1:0] nq_r  [NW];
  logic [31:0]   rem_r [NW];
  logic [31:0]   den_r [NW];
  logic          neg_r [NW];

  for (genvar j = 0; j < NW; j++) begin : g_stage
    logic [NW-1:0] nq_in;
    logic [31:0]   rem_in;
    logic [31:0]   den_in;
    logic          neg_in;
    logic [32:0]   rr;
    logic          ge;

    if (j == 0) begin : g_first
      assign nq_in  = num;
      assign rem_in = '0;
      assign den_in = den;
      assign neg_in = neg;
    end else begin : g_next
      assign nq_in  = nq_r[j-1];
      assign rem_in = rem_r[j-1];
      assign den_in = den_r[j-1];
      assign neg_in = neg_r[j-1];
    end

    assign rr = {rem_in, nq_in[NW-1]};
    assign ge = (rr >= {1'b0, den_in});

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= ge ? 32'(rr - {1'b0, den_in}) : rr[31:0];
        nq_r[j]  <= {nq_in[NW-2:0], ge};
        den_r[j] <= den_in;
        neg_r[j] <= neg_in;
      end
    end
  end

  // saturate the magnitude and apply the sign
  logic [NW-1:0] q;
  logic          over;

  assign q    = nq_r[NW-1];
  assign over = |q[NW-1:31];

  always_comb begin
    if (neg_r[NW-1]) begin
      quot = over ? S32_MIN : -$signed({1'b0, q[30:0]});
    end else begin
      quot = over ? S32_MAX : $signed({1'b0, q[30:0]});
    end
  end

endmodule

FILE: hdl/rab_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_lane
// One axis of the slab test: parallel check, both slab quotients, ordering.
// ----------------------------------------------------------------------------
module rab_lane #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                en,
  input  logic [15:0]         eps,
  input  logic signed [31:0]  org,
  input  logic signed [31:0]  dir,
  input  logic signed [31:0]  lo,
  input  logic signed [31:0]  hi,
  output rab_pkg::lane_res_t  res
);
  import rab_pkg::*;

  localparam int NW = 32 + FRAC_BITS;

  logic signed [32:0] diff_lo, diff_hi, dir_w;
  logic [32:0]        mag_lo, mag_hi, mag_d;

  assign diff_lo = {lo[31], lo} - {org[31], org};
  assign diff_hi = {hi[31], hi} - {org[31], org};
  assign dir_w   = {dir[31], dir};
  assign mag_lo  = diff_lo[32] ? 33'(-diff_lo) : diff_lo;
  assign mag_hi  = diff_hi[32] ? 33'(-diff_hi) : diff_hi;
  assign mag_d   = dir_w[32] ? 33'(-dir_w) : dir_w;

  // prep stage
  logic [NW-1:0] num_lo_r, num_hi_r;
  logic [31:0]   den_r;
  logic          neg_lo_r, neg_hi_r;
  logic [1:0]    flg_r [NW+1];   // {active, miss}

  logic act;
  assign act = (mag_d > {17'b0, eps});

  always_ff @(posedge clk) begin
    if (en) begin
      num_lo_r <= {mag_lo[31:0], {FRAC_BITS{1'b0}}};
      num_hi_r <= {mag_hi[31:0], {FRAC_BITS{1'b0}}};
      den_r    <= mag_d[31:0];
      neg_lo_r <= diff_lo[32] ^ dir[31];
      neg_hi_r <= diff_hi[32] ^ dir[31];
      flg_r[0] <= {act, !act && (org < lo || org > hi)};
      for (int k = 1; k <= NW; k++) begin
        flg_r[k] <= flg_r[k-1];
      end
    end
  end

  logic signed [31:0] q_lo, q_hi;

  rab_div #(.NW(NW)) u_div_lo (
    .clk(clk), .en(en), .num(num_lo_r), .den(den_r), .neg(neg_lo_r), .quot(q_lo)
  );
  rab_div #(.NW(NW)) u_div_hi (
    .clk(clk), .en(en), .num(num_hi_r), .den(den_r), .neg(neg_hi_r), .quot(q_hi)
  );

  // order entry before exit
  logic swp;
  assign swp = (q_lo > q_hi);

  always_ff @(posedge clk) begin
    if (en) begin
      res.active  <= flg_r[NW][1];
      res.miss    <= flg_r[NW][0];
      res.swapped <= swp;
      res.t_in    <= swp ? q_hi : q_lo;
      res.t_out   <= swp ? q_lo : q_hi;
    end
  end

endmodule

FILE: hdl/rab_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rab_merge
// Combine the three lanes into entry distance, entry face and hit.
// ----------------------------------------------------------------------------
module rab_merge (
  input  logic                clk,
  input  logic                en,
  input  rab_pkg::lane_res_t  lanes [rab_pkg::AXES],
  output rab_pkg::merge_res_t res
);
  import rab_pkg::*;

  merge_res_t res_nxt;

  always_comb begin
    logic signed [31:0] tn;
    logic signed [31:0] tf;
    logic [2:0]         fc;
    logic               h;
    tn = '0;
    tf = S32_MAX;
    fc = FACE_NONE;
    h  = 1'b1;
    // earlier axes win ties: update only on a strictly larger entry
    for (int a = 0; a < AXES; a++) begin
      if (lanes[a].active) begin
        if (lanes[a].t_in > tn) begin
          tn = lanes[a].t_in;
          fc = face_of(2'(a), lanes[a].swapped);
        end
        if (lanes[a].t_out < tf) begin
          tf = lanes[a].t_out;
        end
        if (tn > tf) begin
          h = 1'b0;
        end
      end else if (lanes[a].miss) begin
        h = 1'b0;
      end
    end
    res_nxt.hit   = h;
    res_nxt.tnear = tn[30:0];
    res_nxt.face  = fc;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res <= res_nxt;
    end
  end

endmodule

FILE: hdl/ray_aabb_slab_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_aabb_slab_intersection
// Ray versus axis-aligned box slab test, fixed point, one request per cycle.
// ----------------------------------------------------------------------------
// Each request carries a ray and a box; one result comes back per request,
// in order. A new request is taken every cycle while the result side keeps
// up. Numbers are Q16.16 at the default FRAC_BITS. The pipelined slab
// dividers produce one quotient bit per stage. Three lanes, one per axis,
// each hold two dividers (lower and upper corner); a merge stage then
// folds the axes in X, Y, Z order, a multiply stage forms direction times
// entry distance, and the output stage adds the origin.
// The whole pipeline advances together and holds when a result waits on a
// low out_ready. parallel_epsilon is written over the register port at byte
// address 0 and should only change while no request is in flight.
// ----------------------------------------------------------------------------
`include "ray_aabb_slab_intersection_defines.svh"

module ray_aabb_slab_intersection #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  // register port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // request channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_origin_x,
  input  logic signed [31:0] in_origin_y,
  input  logic signed [31:0] in_origin_z,
  input  logic signed [31:0] in_dir_x,
  input  logic signed [31:0] in_dir_y,
  input  logic signed [31:0] in_dir_z,
  input  logic signed [31:0] in_box_min_x,
  input  logic signed [31:0] in_box_min_y,
  input  logic signed [31:0] in_box_min_z,
  input  logic signed [31:0] in_box_max_x,
  input  logic signed [31:0] in_box_max_y,
  input  logic signed [31:0] in_box_max_z,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_hit,
  output logic [30:0]        out_distance,
  output logic signed [31:0] out_point_x,
  output logic signed [31:0] out_point_y,
  output logic signed [31:0] out_point_z,
  output logic [2:0]         out_face_code
);
  import rab_pkg::*;

  // prep stage, divider stages, lane output register
  localparam int LAT = 32 + FRAC_BITS + 2;

  // ---------------- register port ----------------
  logic [15:0] eps_r;
  logic        wr_en;
  logic        eps_wr;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign eps_wr = wr_en && paddr[2] == REG_EPS;
  assign prdata = (paddr[2] == REG_EPS) ? {16'b0, eps_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eps_r <= '0;
    end else if (eps_wr) begin
      eps_r <= pwdata[15:0];
    end
  end

  // ---------------- flow control ----------------
  // Advance every stage together; hold everything while a result stalls.
  logic adv;
  logic out_valid_r;

  assign adv      = !out_valid_r || out_ready;
  assign in_ready = adv;

  logic vld_r [LAT+1];
  logic vld_m_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= LAT; k++) begin
        vld_r[k] <= 1'b0;
      end
      vld_m_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= in_valid;
      for (int k = 1; k <= LAT; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
      vld_m_r     <= vld_r[LAT];
      out_valid_r <= vld_m_r;
    end
  end

  // ---------------- ray side band ----------------
  // Carry origin and direction alongside the lanes for the hit point.
  logic signed [31:0] org_d_r [LAT+1][AXES];
  logic signed [31:0] dir_d_r [LAT+1][AXES];

  always_ff @(posedge clk) begin
    if (adv) begin
      org_d_r[0][0] <= in_origin_x;
      org_d_r[0][1] <= in_origin_y;
      org_d_r[0][2] <= in_origin_z;
      dir_d_r[0][0] <= in_dir_x;
      dir_d_r[0][1] <= in_dir_y;
      dir_d_r[0][2] <= in_dir_z;
      for (int k = 1; k <= LAT; k++) begin
        org_d_r[k] <= org_d_r[k-1];
        dir_d_r[k] <= dir_d_r[k-1];
      end
    end
  end

  // ---------------- axis lanes ----------------
  lane_res_t lane_res [AXES];

  rab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_x (
    .clk(clk), .en(adv), .eps(eps_r), .org(in_origin_x), .dir(in_dir_x),
    .lo(in_box_min_x), .hi(in_box_max_x), .res(lane_res[0])
  );
  rab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_y (
    .clk(clk), .en(adv), .eps(eps_r), .org(in_origin_y), .dir(in_dir_y),
    .lo(in_box_min_y), .hi(in_box_max_y), .res(lane_res[1])
  );
  rab_lane #(.FRAC_BITS(FRAC_BITS)) u_lane_z (
    .clk(clk), .en(adv), .eps(eps_r), .org(in_origin_z), .dir(in_dir_z),
    .lo(in_box_min_z), .hi(in_box_max_z), .res(lane_res[2])
  );

  // ---------------- merge ----------------
  merge_res_t mrg;

  rab_merge u_merge (
    .clk(clk), .en(adv), .lanes(lane_res), .res(mrg)
  );

  // ---------------- multiply stage ----------------
  logic signed [63:0] prod_r [AXES];
  logic signed [31:0] org_m_r [AXES];
  merge_res_t         mrg_m_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int a = 0; a < AXES; a++) begin
        prod_r[a]  <= dir_d_r[LAT][a] * $signed({1'b0, mrg.tnear});
        org_m_r[a] <= org_d_r[LAT][a];
      end
      mrg_m_r <= mrg;
    end
  end

  // ---------------- output stage ----------------
  // Floor-shift the product, saturate, add the origin, saturate again.
  logic signed [31:0] pt_nxt [AXES];

  always_comb begin
    logic signed [31:0] sc;
    logic signed [32:0] sum;
    for (int a = 0; a < AXES; a++) begin
      sc        = sat64_to32(prod_r[a] >>> FRAC_BITS);
      sum       = {org_m_r[a][31], org_m_r[a]} + {sc[31], sc};
      pt_nxt[a] = sat64_to32(64'(sum));
    end
  end

  logic               hit_r;
  logic [30:0]        dist_r;
  logic [2:0]         face_r;
  logic signed [31:0] pt_r [AXES];

  always_ff @(posedge clk) begin
    if (adv) begin
      hit_r  <= mrg_m_r.hit;
      dist_r <= mrg_m_r.hit ? mrg_m_r.tnear : '0;
      face_r <= mrg_m_r.hit ? mrg_m_r.face : FACE_NONE;
      for (int a = 0; a < AXES; a++) begin
        pt_r[a] <= mrg_m_r.hit ? pt_nxt[a] : '0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_hit       = hit_r;
  assign out_distance  = dist_r;
  assign out_point_x   = pt_r[0];
  assign out_point_y   = pt_r[1];
  assign out_point_z   = pt_r[2];
  assign out_face_code = face_r;

  // ---------------- checks ----------------
  logic res_zero;
  logic face_dist_ok;

  assign res_zero     = out_distance == '0 && out_face_code == FACE_NONE &&
                        out_point_x == '0 && out_point_y == '0 && out_point_z == '0;
  assign face_dist_ok = (out_face_code == FACE_NONE) == (out_distance == '0);

  `RAB_ASSERT_IMP(a_miss_zero, out_valid && !out_hit, res_zero, "miss result not all zero")
  `RAB_ASSERT_IMP(a_face_dist, out_valid && out_hit, face_dist_ok, "face and distance disagree")
  `RAB_ASSERT(a_eps_write, ($past(rst_n) && $past(eps_wr)) |-> eps_r == $past(pwdata[15:0]), "eps lost")

endmodule
